### rtl/core/rfps_pkg.sv
`default_nettype none
package rfps_pkg;

  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_REF_PRESSURE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_ACCEL  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_MARGIN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EJECT_SAMPLES = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPLOY_HOLD   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_WINDOW = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DESCENT   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_MARGIN = 4'd7;

  localparam logic [2:0] PH_PRE     = 3'd0;
  localparam logic [2:0] PH_ASCENT  = 3'd1;
  localparam logic [2:0] PH_DEPLOY  = 3'd2;
  localparam logic [2:0] PH_DESCENT = 3'd3;
  localparam logic [2:0] PH_SHUT    = 3'd4;

  localparam longint ALT_SCALE_CM  = 64'sd4433000;
  localparam logic [17:0] RATIO_MAX_Q16 = 18'd131072;
  localparam logic [29:0] LANDING_MAG2  = 30'd1210000;
  localparam logic [7:0]  STEADY_NEEDED = 8'd3;

  // sample as it travels from the front end to the sequencer
  typedef struct packed {
    logic [31:0]        time_ms;
    logic signed [13:0] accel_x_mg;
    logic [16:0]        pressure_pa;
    logic               button_pressed;
    logic               mag_low;
  } entry_t;

  // log2 of a Q20 value, result in Q24; evaluated at elaboration only
  function automatic longint log2_q24(input longint unsigned v);
    int p;
    longint unsigned m;
    longint frac;
    p = 0;
    frac = 0;
    for (int j = 1; j < 64; j++) begin
      if ((v >> j) != 0) p = j;
    end
    m = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(p - 20) * 64'sd16777216 + frac;
  endfunction

endpackage
`default_nettype wire

### rtl/core/rfps_if.sv
`default_nettype none
interface rfps_sample_if;
  logic               valid;
  logic               ready;
  logic [31:0]        time_ms;
  logic signed [13:0] accel_x_mg;
  logic signed [13:0] accel_y_mg;
  logic signed [13:0] accel_z_mg;
  logic [16:0]        pressure_pa;
  logic               button_pressed;
  modport source (output valid, time_ms, accel_x_mg, accel_y_mg, accel_z_mg,
                  pressure_pa, button_pressed, input ready);
  modport sink (input valid, time_ms, accel_x_mg, accel_y_mg, accel_z_mg,
                pressure_pa, button_pressed, output ready);
endinterface

interface rfps_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         phase;
  logic               chute_fire;
  logic signed [23:0] altitude_cm;
  logic signed [23:0] peak_altitude_cm;
  modport source (output valid, phase, chute_fire, altitude_cm, peak_altitude_cm,
                  input ready);
  modport sink (input valid, phase, chute_fire, altitude_cm, peak_altitude_cm,
                output ready);
endinterface

interface rfps_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/rocket_flight_phase_sequencer.sv
// Flight phase sequencer: one result per sensor sample.
// smp_i   : sample request (time, xyz acceleration, pressure, button), valid/ready.
// res_o   : result request (phase, chute level, filtered and peak altitude).
// cfg_i   : register writes (index, data), always ready; write only while idle.
// A front stage registers the sample and forms the acceleration magnitude test,
// a two-entry queue decouples it from the sequencer, which owns all flight state.
// Steps: samples that need no altitude go from evaluation straight to the result;
// samples that do (ascent with valid pressure, deploy exit, descent) pass on
// through the 38-step serial divide of the pressure ratio, table interpolation and
// the filter, whose divide by ten is a reciprocal multiply. With a zero
// reference pressure the divide is skipped. One sample is processed at a time:
// the next is taken only once the result of the last one has been taken.
// Reset restores the register defaults and puts the block in pre-flight.
// When the receiver stalls the result holds; the front and the queue still
// take up to three more samples before smp_i.ready drops.
`default_nettype none
module rocket_flight_phase_sequencer #(
  parameter int unsigned ALT_TABLE_ENTRIES = 256
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  rfps_sample_if.sink   smp_i,
  rfps_cfg_if.sink      cfg_i,
  rfps_result_if.source res_o
);

  rfps_pkg::entry_t push_entry, pop_entry;
  logic push, pop, full, empty;

  rfps_front u_front (
    .clk_i, .rst_ni, .smp_i, .entry_o(push_entry), .push_o(push), .full_i(full)
  );

  rfps_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(push_entry), .full_o(full),
    .pop_i(pop), .rdata_o(pop_entry), .empty_o(empty)
  );

  rfps_back #(.ALT_TABLE_ENTRIES(ALT_TABLE_ENTRIES)) u_back (
    .clk_i, .rst_ni, .cfg_i, .entry_i(pop_entry), .empty_i(empty), .pop_o(pop),
    .res_o
  );

endmodule
`default_nettype wire

### rtl/core/rfps_front.sv
`default_nettype none
module rfps_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  rfps_sample_if.sink        smp_i,
  output rfps_pkg::entry_t   entry_o,
  output logic               push_o,
  input  wire logic          full_i
);

  logic               valid_q;
  logic [31:0]        time_q;
  logic signed [13:0] ax_q, ay_q, az_q;
  logic [16:0]        pres_q;
  logic               btn_q;
  logic [27:0]        sx, sy, sz;
  logic [29:0]        mag2;

  assign push_o    = valid_q && !full_i;
  assign smp_i.ready = !valid_q || !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (smp_i.ready) begin
      valid_q <= smp_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_i.valid && smp_i.ready) begin
      time_q <= smp_i.time_ms;
      ax_q   <= smp_i.accel_x_mg;
      ay_q   <= smp_i.accel_y_mg;
      az_q   <= smp_i.accel_z_mg;
      pres_q <= smp_i.pressure_pa;
      btn_q  <= smp_i.button_pressed;
    end
  end

  // squares are non-negative, so the signed products fit unsigned 28 bits
  always_comb begin
    sx   = 28'(ax_q * ax_q);
    sy   = 28'(ay_q * ay_q);
    sz   = 28'(az_q * az_q);
    mag2 = 30'(sx) + 30'(sy) + 30'(sz);
    entry_o.time_ms        = time_q;
    entry_o.accel_x_mg     = ax_q;
    entry_o.pressure_pa    = pres_q;
    entry_o.button_pressed = btn_q;
    entry_o.mag_low        = (mag2 < rfps_pkg::LANDING_MAG2);
  end

endmodule
`default_nettype wire

### rtl/core/rfps_fifo.sv
`default_nettype none
module rfps_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  rfps_pkg::entry_t wdata_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output rfps_pkg::entry_t rdata_o,
  output logic             empty_o
);

  rfps_pkg::entry_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");

endmodule
`default_nettype wire

### rtl/core/rfps_div.sv
`default_nettype none
module rfps_div #(
  parameter int unsigned W  = 38,
  parameter int unsigned DW = 17
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  dvd_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [DW:0]   sh;
  logic          fit;

  assign quot_o = dvd_q;
  assign sh  = {rem_q, dvd_q[W-1]};
  assign fit = (sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so it fits DW bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= DW'(fit ? (sh - {1'b0, dvs_q}) : sh);
      dvd_q <= {dvd_q[W-2:0], fit};
    end
  end

endmodule
`default_nettype wire

### rtl/core/rfps_back.sv
`default_nettype none
module rfps_back #(
  parameter int unsigned ALT_TABLE_ENTRIES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rfps_cfg_if.sink         cfg_i,
  input  rfps_pkg::entry_t entry_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  rfps_result_if.source    res_o
);

  localparam int unsigned N   = ALT_TABLE_ENTRIES;
  localparam int unsigned IW  = $clog2(N + 1);
  localparam int unsigned PW  = 18 + IW;
  localparam int unsigned DVW = 38;

  // ceil(2^35 / 10): exact divide by ten for any 32-bit operand
  localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_EVAL   = 4'd1;
  localparam logic [3:0] ST_RDIV   = 4'd2;
  localparam logic [3:0] ST_POS    = 4'd3;
  localparam logic [3:0] ST_INTERP = 4'd4;
  localparam logic [3:0] ST_RAW    = 4'd5;
  localparam logic [3:0] ST_FDIV   = 4'd6;
  localparam logic [3:0] ST_APPLY  = 4'd7;

  function automatic logic [(N+1)*32-1:0] build_rom();
    logic [(N+1)*32-1:0] r;
    longint unsigned x, lo, hi, mid;
    longint target, a;
    r = '0;
    r[31:0] = 32'(rfps_pkg::ALT_SCALE_CM);
    for (int k = 1; k <= N; k++) begin
      x = (longint'(k) << 21) / N;
      target = 64'sd1903 * rfps_pkg::log2_q24(x);
      lo = 1;
      hi = (64'd1 << 21) - 1;
      for (int s = 0; s < 24; s++) begin
        if (hi - lo > 1) begin
          mid = (lo + hi) >> 1;
          if (64'sd10000 * rfps_pkg::log2_q24(mid) <= target) lo = mid;
          else hi = mid;
        end
      end
      a = rfps_pkg::ALT_SCALE_CM
          - longint'((longint'(rfps_pkg::ALT_SCALE_CM) * lo + 524288) >> 20);
      r[k*32 +: 32] = 32'(a);
    end
    return r;
  endfunction

  localparam logic [(N+1)*32-1:0] ALT_ROM = build_rom();

  // configuration
  logic [16:0] ref_q;
  logic [12:0] launch_q;
  logic [15:0] drop_m_q, hold_q, stable_q;
  logic [7:0]  eject_q;
  logic [19:0] ignore_q, maxd_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= 17'd101325;
      launch_q <= 13'd1800;
      drop_m_q <= 16'd100;
      eject_q  <= 8'd5;
      hold_q   <= 16'd5000;
      ignore_q <= 20'd10000;
      maxd_q   <= 20'd30000;
      stable_q <= 16'd50;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rfps_pkg::REG_REF_PRESSURE:  ref_q    <= cfg_i.data[16:0];
        rfps_pkg::REG_LAUNCH_ACCEL:  launch_q <= cfg_i.data[12:0];
        rfps_pkg::REG_DROP_MARGIN:   drop_m_q <= cfg_i.data[15:0];
        rfps_pkg::REG_EJECT_SAMPLES: eject_q  <= cfg_i.data[7:0];
        rfps_pkg::REG_DEPLOY_HOLD:   hold_q   <= cfg_i.data[15:0];
        rfps_pkg::REG_IGNORE_WINDOW: ignore_q <= cfg_i.data[19:0];
        rfps_pkg::REG_MAX_DESCENT:   maxd_q   <= cfg_i.data[19:0];
        rfps_pkg::REG_STABLE_MARGIN: stable_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // flight state
  logic [3:0]         st_q;
  logic [2:0]         phase_q;
  logic signed [31:0] filt_q, peak_q, prev_q;
  logic [7:0]         drop_q, steady_q;
  logic [31:0]        mark_q;
  logic               chute_q;
  rfps_pkg::entry_t   cur_q;
  logic [31:0]        dt_q;

  // altitude datapath
  logic [17:0]        ratio_q;
  logic [PW-1:0]      pos_q;
  logic signed [31:0] a0_q;
  logic signed [50:0] prod_q;
  logic               neg_q;
  logic [31:0]        fmag_q;
  logic [28:0]        quo_q;
  logic [63:0]        qprod;
  logic signed [31:0] fnew;

  logic               div_start, div_done;
  logic [DVW-1:0]     div_dvd, div_q;
  logic [16:0]        div_dvs;

  rfps_div #(.W(DVW), .DW(17)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dvd),
    .divisor_i(div_dvs), .done_o(div_done), .quot_o(div_q)
  );

  logic               need_alt;
  logic [IW-1:0]      idx;
  logic [16:0]        frac;
  logic signed [31:0] rom_a0, rom_a1;
  logic signed [32:0] delta;
  logic signed [31:0] raw;
  logic signed [37:0] fsum;
  logic [37:0]        fmag;
  logic signed [32:0] ddiff, adiff;
  logic [7:0]         drop_inc, steady_inc, steady_new;

  always_comb begin
    idx    = IW'(pos_q >> 17);
    frac   = pos_q[16:0];
    rom_a0 = ALT_ROM[32'(idx) * 32 +: 32];
    rom_a1 = (32'(idx) >= N) ? rom_a0 : ALT_ROM[(32'(idx) + 1) * 32 +: 32];
    delta  = 33'(rom_a1) - 33'(rom_a0);
    raw    = a0_q + 32'(prod_q >>> 17);
    fsum   = 38'(filt_q) * 38'sd9 + 38'(raw) + 38'sd5;
    // floor division of a negative sum: divide the magnitude rounded up
    fmag   = (fsum < 0) ? 38'(-fsum + 38'sd9) : 38'(fsum);
    qprod  = 64'(fmag_q) * 64'(RECIP_10);
    fnew   = neg_q ? -$signed({3'b000, quo_q}) : $signed({3'b000, quo_q});
    ddiff  = 33'(peak_q) - 33'(fnew);
    adiff  = 33'(fnew) - 33'(prev_q);
    if (adiff < 0) adiff = -adiff;
    drop_inc   = (drop_q == 8'hFF) ? drop_q : drop_q + 8'd1;
    steady_inc = (steady_q == 8'hFF) ? steady_q : steady_q + 8'd1;
    steady_new = (adiff < 33'(stable_q)) ? steady_inc : 8'd0;
    unique case (phase_q)
      rfps_pkg::PH_ASCENT:  need_alt = (cur_q.pressure_pa != 17'd0);
      rfps_pkg::PH_DEPLOY:  need_alt = (dt_q >= 32'(hold_q));
      rfps_pkg::PH_DESCENT: need_alt = 1'b1;
      default:              need_alt = 1'b0;
    endcase
    div_start = (st_q == ST_EVAL) && need_alt && (ref_q != 17'd0);
    div_dvd   = DVW'({cur_q.pressure_pa, 16'd0});
    div_dvs   = ref_q;
  end

  assign pop_o = (st_q == ST_IDLE) && !empty_i && !res_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      phase_q  <= rfps_pkg::PH_PRE;
      filt_q   <= '0;
      peak_q   <= '0;
      prev_q   <= '0;
      drop_q   <= '0;
      steady_q <= '0;
      mark_q   <= '0;
      chute_q  <= 1'b0;
      res_o.valid <= 1'b0;
    end else begin
      if (res_o.valid && res_o.ready) res_o.valid <= 1'b0;
      unique case (st_q)
        ST_IDLE: if (pop_o) st_q <= ST_EVAL;
        ST_EVAL: begin
          if (phase_q == rfps_pkg::PH_PRE &&
              $signed({cur_q.accel_x_mg[13], cur_q.accel_x_mg}) >
              $signed({2'b00, launch_q})) begin
            phase_q <= rfps_pkg::PH_ASCENT;
          end
          if (phase_q == rfps_pkg::PH_DEPLOY) chute_q <= 1'b1;
          if (!need_alt) begin
            res_o.valid <= 1'b1;
            st_q <= ST_IDLE;
          end else if (ref_q == 17'd0) begin
            st_q <= ST_POS;
          end else begin
            st_q <= ST_RDIV;
          end
        end
        ST_RDIV:   if (div_done) st_q <= ST_POS;
        ST_POS:    st_q <= ST_INTERP;
        ST_INTERP: st_q <= ST_RAW;
        ST_RAW:    st_q <= ST_FDIV;
        ST_FDIV:   st_q <= ST_APPLY;
        ST_APPLY: begin
          res_o.valid <= 1'b1;
          st_q <= ST_IDLE;
          unique case (phase_q)
            rfps_pkg::PH_ASCENT: begin
              filt_q <= fnew;
              if (fnew > peak_q) begin
                peak_q <= fnew;
                drop_q <= '0;
              end else if (ddiff >= 33'(drop_m_q)) begin
                drop_q <= drop_inc;
                if (drop_inc >= eject_q) begin
                  phase_q <= rfps_pkg::PH_DEPLOY;
                  mark_q  <= cur_q.time_ms;
                end
              end
            end
            rfps_pkg::PH_DEPLOY: begin
              chute_q <= 1'b0;
              prev_q  <= fnew;
              mark_q  <= cur_q.time_ms;
              phase_q <= rfps_pkg::PH_DESCENT;
            end
            rfps_pkg::PH_DESCENT: begin
              filt_q <= fnew;
              if (dt_q < 32'(ignore_q)) begin
                prev_q <= fnew;
              end else if (dt_q > 32'(maxd_q)) begin
                phase_q <= rfps_pkg::PH_SHUT;
              end else begin
                steady_q <= steady_new;
                if ((cur_q.mag_low && steady_new > rfps_pkg::STEADY_NEEDED) ||
                    cur_q.button_pressed) begin
                  phase_q <= rfps_pkg::PH_SHUT;
                end
              end
            end
            default: ;
          endcase
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
      dt_q  <= entry_i.time_ms - mark_q;
    end
    if (st_q == ST_EVAL) ratio_q <= rfps_pkg::RATIO_MAX_Q16;
    if (st_q == ST_RDIV && div_done) begin
      ratio_q <= (div_q > DVW'(rfps_pkg::RATIO_MAX_Q16)) ? rfps_pkg::RATIO_MAX_Q16
                                                          : div_q[17:0];
    end
    if (st_q == ST_POS) pos_q <= PW'(ratio_q) * PW'(N);
    if (st_q == ST_INTERP) begin
      a0_q   <= rom_a0;
      prod_q <= 51'(delta) * $signed({1'b0, frac});
    end
    // altitudes stay well inside 2^31 / 10, so the magnitude fits 32 bits
    if (st_q == ST_RAW) begin
      neg_q  <= (fsum < 0);
      fmag_q <= fmag[31:0];
    end
    if (st_q == ST_FDIV) quo_q <= qprod[63:35];
  end

  always_comb begin
    res_o.phase      = phase_q;
    res_o.chute_fire = chute_q;
    if (filt_q > 32'sd8388607)       res_o.altitude_cm = 24'sh7FFFFF;
    else if (filt_q < -32'sd8388608) res_o.altitude_cm = 24'sh800000;
    else                             res_o.altitude_cm = filt_q[23:0];
    if (peak_q > 32'sd8388607)       res_o.peak_altitude_cm = 24'sh7FFFFF;
    else if (peak_q < -32'sd8388608) res_o.peak_altitude_cm = 24'sh800000;
    else                             res_o.peak_altitude_cm = peak_q[23:0];
  end

  a_chute_in_deploy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chute_q |-> phase_q == rfps_pkg::PH_DEPLOY) else $error("chute outside deploy");
  a_shut_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rfps_pkg::PH_SHUT |=> phase_q == rfps_pkg::PH_SHUT)
    else $error("left shutdown");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> st_q == ST_EVAL) else $error("pop without evaluation");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> st_q == ST_RDIV) else $error("stray divide");

endmodule
`default_nettype wire

### tb/sv/rocket_flight_phase_sequencer_test.sv
`default_nettype none
module rocket_flight_phase_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rfps_pkg::*;

  localparam int N_ITEMS = 1650;
  localparam int TABLE_N = 256;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 120;
  localparam int LONG_HOLD = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;

  typedef struct {
    logic [31:0]        t;
    logic signed [13:0] ax, ay, az;
    logic [16:0]        pres;
    logic               btn;
  } sample_t;

  typedef struct {
    logic [2:0]         phase;
    logic               chute;
    logic signed [23:0] alt;
    logic signed [23:0] peak;
  } flight_out_t;

  class flight_scoreboard;
    int alt_rom[TABLE_N + 1];
    logic [31:0] regs[8];
    logic [2:0] phase;
    int filt, peak, prev_alt;
    int drop_n, steady_n;
    logic [31:0] mark;
    logic chute;
    flight_out_t expected_q[$];
    int errors;

    function new();
      longint unsigned x, lo, hi, mid;
      longint target;
      alt_rom[0] = 4433000;
      for (int k = 1; k <= TABLE_N; k++) begin
        x = (longint'(k) << 21) / TABLE_N;
        target = 1903 * lg2_q24(x);
        lo = 1;
        hi = (64'd1 << 21) - 1;
        while (hi - lo > 1) begin
          mid = (lo + hi) >> 1;
          if (10000 * lg2_q24(mid) <= target) lo = mid;
          else hi = mid;
        end
        alt_rom[k] = 4433000 - int'((64'd4433000 * lo + 64'd524288) >> 20);
      end
      regs = '{101325, 1800, 100, 5, 5000, 10000, 30000, 50};
      phase = PH_PRE;
      filt = 0; peak = 0; prev_alt = 0;
      drop_n = 0; steady_n = 0;
      mark = 0; chute = 0;
      errors = 0;
    endfunction

    // Q20 in, Q24 log2 out; fraction bits by repeated squaring
    function longint lg2_q24(longint unsigned v);
      int p;
      longint unsigned m;
      longint fr;
      p = 0;
      fr = 0;
      for (int j = 1; j < 64; j++) if ((v >> j) != 0) p = j;
      m = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 30;
        fr = fr << 1;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          fr = fr | 1;
        end
      end
      return longint'(p - 20) * 16777216 + fr;
    endfunction

    function longint fdiv10(longint s);
      if (s >= 0) return s / 10;
      return -((-s + 9) / 10);
    endfunction

    function int baro_alt(logic [16:0] pres);
      longint unsigned q, pos, idx, fr;
      longint delta;
      if (regs[REG_REF_PRESSURE] == 0) q = RATIO_MAX_Q16;
      else q = (longint'(pres) << 16) / regs[REG_REF_PRESSURE];
      if (q > RATIO_MAX_Q16) q = RATIO_MAX_Q16;
      pos = q * TABLE_N;
      idx = pos >> 17;
      fr = pos & 64'h1FFFF;
      if (idx >= TABLE_N) return alt_rom[TABLE_N];
      delta = longint'(alt_rom[idx + 1]) - longint'(alt_rom[idx]);
      return int'(longint'(alt_rom[idx]) + ((delta * longint'(fr)) >>> 17));
    endfunction

    function int smooth(int old, int raw);
      return int'(fdiv10(9 * longint'(old) + longint'(raw) + 5));
    endfunction

    function logic signed [23:0] sat24(int v);
      if (v > 8388607) return 24'sh7FFFFF;
      if (v < -8388608) return 24'sh800000;
      return v[23:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        REG_REF_PRESSURE:  regs[idx] = d & 32'h1FFFF;
        REG_LAUNCH_ACCEL:  regs[idx] = d & 32'h1FFF;
        REG_DROP_MARGIN:   regs[idx] = d & 32'hFFFF;
        REG_EJECT_SAMPLES: regs[idx] = d & 32'hFF;
        REG_DEPLOY_HOLD:   regs[idx] = d & 32'hFFFF;
        REG_IGNORE_WINDOW: regs[idx] = d & 32'hFFFFF;
        REG_MAX_DESCENT:   regs[idx] = d & 32'hFFFFF;
        REG_STABLE_MARGIN: regs[idx] = d & 32'hFFFF;
        default: ;
      endcase
    endfunction

    function void note_sample(sample_t s);
      logic [31:0] dt;
      longint ax, ay, az, diff;
      flight_out_t r;
      dt = s.t - mark;
      ax = s.ax;
      ay = s.ay;
      az = s.az;
      case (phase)
        PH_PRE: if (ax > longint'(regs[REG_LAUNCH_ACCEL])) phase = PH_ASCENT;
        PH_ASCENT: if (s.pres != 0) begin
          filt = smooth(filt, baro_alt(s.pres));
          if (filt > peak) begin
            peak = filt;
            drop_n = 0;
          end else if (longint'(peak) - filt >= longint'(regs[REG_DROP_MARGIN])) begin
            if (drop_n < 255) drop_n++;
            if (drop_n >= regs[REG_EJECT_SAMPLES]) begin
              phase = PH_DEPLOY;
              mark = s.t;
            end
          end
        end
        PH_DEPLOY: begin
          chute = 1;
          if (dt >= regs[REG_DEPLOY_HOLD]) begin
            chute = 0;
            prev_alt = smooth(filt, baro_alt(s.pres));
            mark = s.t;
            phase = PH_DESCENT;
          end
        end
        PH_DESCENT: begin
          filt = smooth(filt, baro_alt(s.pres));
          if (dt < regs[REG_IGNORE_WINDOW]) prev_alt = filt;
          else if (dt > regs[REG_MAX_DESCENT]) phase = PH_SHUT;
          else begin
            diff = longint'(filt) - prev_alt;
            if (diff < 0) diff = -diff;
            if (diff < longint'(regs[REG_STABLE_MARGIN])) begin
              if (steady_n < 255) steady_n++;
            end else begin
              steady_n = 0;
            end
            if (ax * ax + ay * ay + az * az < LANDING_MAG2 && steady_n > STEADY_NEEDED)
              phase = PH_SHUT;
            else if (s.btn) phase = PH_SHUT;
          end
        end
        default: ;
      endcase
      r.phase = phase;
      r.chute = chute;
      r.alt = sat24(filt);
      r.peak = sat24(peak);
      expected_q.push_back(r);
    endfunction

    function void check_result(flight_out_t got);
      flight_out_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.phase !== e.phase) begin
        $error("phase: expected %0d, got %0d", e.phase, got.phase);
        errors++;
      end
      if (got.chute !== e.chute) begin
        $error("chute_fire: expected %0d, got %0d", e.chute, got.chute);
        errors++;
      end
      if (got.alt !== e.alt) begin
        $error("altitude_cm: expected %0d, got %0d", e.alt, got.alt);
        errors++;
      end
      if (got.peak !== e.peak) begin
        $error("peak_altitude_cm: expected %0d, got %0d", e.peak, got.peak);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  rfps_sample_if smp();
  rfps_cfg_if    cfg();
  rfps_result_if res();

  rocket_flight_phase_sequencer DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .smp_i (smp),
    .cfg_i (cfg),
    .res_o (res)
  );

  flight_scoreboard sb = new();
  bit no_idle;
  bit long_hold_req;
  int cycles;
  int n_sent;
  logic [31:0] t_now;
  int p_cur;
  int asc_n;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    flight_out_t got;
    if (rst_ni && res.valid && res.ready) begin
      got.phase = res.phase;
      got.chute = res.chute_fire;
      got.alt = res.altitude_cm;
      got.peak = res.peak_altitude_cm;
      sb.check_result(got);
    end
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    res.ready = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        res.ready <= 0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold_req = 0;
      end else if (no_idle) begin
        res.ready <= 1;
      end else begin
        res.ready <= ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end
    end
  end

  task automatic send_sample(sample_t s);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      smp.valid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    smp.valid <= 1;
    smp.time_ms <= s.t;
    smp.accel_x_mg <= s.ax;
    smp.accel_y_mg <= s.ay;
    smp.accel_z_mg <= s.az;
    smp.pressure_pa <= s.pres;
    smp.button_pressed <= s.btn;
    do @(posedge clk_i); while (!smp.ready);
    sb.note_sample(s);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    smp.valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    @(negedge clk_i);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk_i); while (!cfg.ready);
    sb.write_reg(idx, d);
  endtask

  task automatic cfg_done();
    @(negedge clk_i);
    cfg.valid <= 0;
  endtask

  function automatic sample_t any_sample();
    sample_t s;
    s.t = $urandom;
    s.ax = $urandom;
    s.ay = $urandom;
    s.az = $urandom;
    s.pres = $urandom_range(0, 131071);
    s.btn = $urandom;
    return s;
  endfunction

  function automatic int jitter(int w);
    return $urandom_range(0, 2 * w) - w;
  endfunction

  // well-formed flight profile, driven by where the flight model currently is
  function automatic sample_t flight_sample();
    sample_t s;
    s = any_sample();
    s.btn = 0;
    case (sb.phase)
      PH_PRE: begin
        t_now += $urandom_range(1, 20);
        if ($urandom_range(0, 19) == 0)
          s.ax = $urandom_range(sb.regs[REG_LAUNCH_ACCEL] + 1, 8191);
        else
          s.ax = -$urandom_range(0, 8192 - sb.regs[REG_LAUNCH_ACCEL]) + 
                 int'(sb.regs[REG_LAUNCH_ACCEL]);
        s.pres = p_cur + jitter(20);
      end
      PH_ASCENT: begin
        t_now += $urandom_range(1, 20);
        if (asc_n < 250) p_cur -= $urandom_range(0, 120);
        else p_cur += $urandom_range(0, 150);
        if (p_cur < 1) p_cur = 1;
        if (p_cur > 131000) p_cur = 131000;
        s.pres = p_cur + jitter(30);
        if ($urandom_range(0, 14) == 0) s.pres = 0;
        else if ($urandom_range(0, 39) == 0) s.pres = $urandom_range(0, 131071);
        asc_n++;
      end
      PH_DEPLOY, PH_DESCENT: begin
        t_now += $urandom_range(50, 400);
        s.ax = 1000 + jitter(60);
        s.ay = jitter(60);
        s.az = jitter(60);
        s.pres = p_cur + jitter(3);
        if ($urandom_range(0, 99) == 0) s.pres = 0;
        if ($urandom_range(0, 7) == 0) s.ax = $urandom;
        s.btn = ($urandom_range(0, 299) == 0);
      end
      default: ;
    endcase
    s.t = t_now;
    return s;
  endfunction

  initial begin
    sample_t s;
    bit shut_cfg_done;
    cycles = 0;
    n_sent = 0;
    asc_n = 0;
    no_idle = 0;
    long_hold_req = 0;
    shut_cfg_done = 0;
    rst_ni = 0;
    smp.valid = 0;
    smp.time_ms = 0;
    smp.accel_x_mg = 0;
    smp.accel_y_mg = 0;
    smp.accel_z_mg = 0;
    smp.pressure_pa = 0;
    smp.button_pressed = 0;
    cfg.valid = 0;
    cfg.index = REG_REF_PRESSURE;
    cfg.data = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // field extremes on the ground, launch threshold reached but not exceeded
    for (int i = 0; i < 12; i++) begin
      s.t = (i % 2) ? 32'hFFFF_FFFF : 32'h0;
      s.ax = (i % 3 == 0) ? -14'sd8192 : 14'sd1800;
      s.ay = (i % 2) ? 14'sd8191 : -14'sd8192;
      s.az = (i % 4 < 2) ? -14'sd8192 : 14'sd8191;
      s.pres = (i % 3 == 1) ? 17'd131071 : ((i % 3 == 2) ? 17'd0 : 17'd101325);
      s.btn = i[1];
      send_sample(s);
    end
    drain();

    // top of every register range; launch at 8191 keeps the flight on the pad
    write_reg(REG_REF_PRESSURE, 131071);
    write_reg(REG_LAUNCH_ACCEL, 8191);
    write_reg(REG_DROP_MARGIN, 65535);
    write_reg(REG_EJECT_SAMPLES, 255);
    write_reg(REG_DEPLOY_HOLD, 65535);
    write_reg(REG_IGNORE_WINDOW, 1048575);
    write_reg(REG_MAX_DESCENT, 1048575);
    write_reg(REG_STABLE_MARGIN, 65535);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_done();
    for (int i = 0; i < 300; i++) begin
      if (i == 60) long_hold_req = 1;
      send_sample(any_sample());
    end
    drain();

    // flight settings; eject count starts at 255 so the drop counter saturates
    write_reg(REG_REF_PRESSURE, $urandom_range(90000, 120000));
    write_reg(REG_LAUNCH_ACCEL, $urandom_range(500, 3000));
    write_reg(REG_DROP_MARGIN, $urandom_range(50, 400));
    write_reg(REG_EJECT_SAMPLES, 255);
    write_reg(REG_DEPLOY_HOLD, $urandom_range(1000, 6000));
    write_reg(REG_IGNORE_WINDOW, $urandom_range(2000, 10000));
    write_reg(REG_MAX_DESCENT, $urandom_range(20000, 40000));
    write_reg(REG_STABLE_MARGIN, $urandom_range(20, 300));
    cfg_done();
    p_cur = sb.regs[REG_REF_PRESSURE];
    t_now = 32'hFFFF_FFFF - $urandom_range(0, 4000);

    while (n_sent < N_ITEMS) begin
      if (N_ITEMS - n_sent == 200) no_idle = 1;
      if (sb.phase == PH_ASCENT && asc_n == 240) begin
        drain();
        write_reg(REG_REF_PRESSURE, 0);
        cfg_done();
        repeat (10) send_sample(flight_sample());
        drain();
        write_reg(REG_REF_PRESSURE, 1);
        cfg_done();
        repeat (10) send_sample(flight_sample());
        drain();
        write_reg(REG_REF_PRESSURE, $urandom_range(90000, 120000));
        cfg_done();
      end
      if (sb.phase == PH_ASCENT && asc_n == 600) begin
        drain();
        write_reg(REG_DROP_MARGIN, 0);
        write_reg(REG_EJECT_SAMPLES, 0);
        cfg_done();
      end
      if (sb.phase == PH_SHUT && !shut_cfg_done) begin
        shut_cfg_done = 1;
        drain();
        write_reg(REG_REF_PRESSURE, 1);
        write_reg(REG_LAUNCH_ACCEL, 0);
        write_reg(REG_DROP_MARGIN, 0);
        write_reg(REG_EJECT_SAMPLES, 1);
        write_reg(REG_DEPLOY_HOLD, 0);
        write_reg(REG_IGNORE_WINDOW, 0);
        write_reg(REG_MAX_DESCENT, 0);
        write_reg(REG_STABLE_MARGIN, 0);
        cfg_done();
      end
      if (sb.phase == PH_SHUT) send_sample(any_sample());
      else send_sample(flight_sample());
    end

    @(negedge clk_i);
    smp.valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
rtl/core/rfps_pkg.sv
rtl/core/rfps_if.sv
rtl/core/rfps_front.sv
rtl/core/rfps_fifo.sv
rtl/core/rfps_div.sv
rtl/core/rfps_back.sv
rtl/core/rocket_flight_phase_sequencer.sv
tb/sv/rocket_flight_phase_sequencer_test.sv
